/* hw/rtl/date_check_and_day_number_assert.svh */
// assertion macros for the dated-record checker
// expects clk and rst_n to be visible where a macro is used
`ifndef DATE_CHECK_AND_DAY_NUMBER_ASSERT_SVH
`define DATE_CHECK_AND_DAY_NUMBER_ASSERT_SVH

// same-cycle implication
`define DCDN_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// implication checked in the next cycle
`define DCDN_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hw/rtl/dcdn_pkg.sv */
// types, status codes and calendar tables for the dated-record checker
// no dependencies
package dcdn_pkg;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_BAD_DATE = 2'd1,
        ST_EARLY    = 2'd2,
        ST_NOT_POS  = 2'd3
    } status_t;

    typedef struct packed {
        logic        [11:0] year;
        logic        [3:0]  month;
        logic        [4:0]  day;
        logic signed [15:0] points;
    } rec_word_t;

    typedef struct packed {
        status_t     status;
        logic [19:0] day_number;
    } res_word_t;

    localparam logic [11:0] BASE_YEAR     = 12'd1800;
    // leap years in 1..1799
    localparam logic [10:0] BASE_LEAPS    = 11'd436;
    localparam logic [19:0] DAYS_PER_YEAR = 20'd365;
    // floor(n / 100) == (n * RECIP_100) >> RECIP_SHIFT for n below 4096
    localparam logic [12:0] RECIP_100     = 13'd5243;
    localparam int          RECIP_SHIFT   = 19;

    // days in the months before month m of a common year
    localparam logic [8:0] CUM_DAYS [16] = '{
        9'd0,   9'd0,   9'd31,  9'd59,  9'd90,  9'd120, 9'd151, 9'd181,
        9'd212, 9'd243, 9'd273, 9'd304, 9'd334, 9'd0,   9'd0,   9'd0
    };

    // month length, zero for a month number out of range
    function automatic logic [4:0] month_days(input logic [3:0] m, input logic leap);
        logic [4:0] len;
        case (m) inside
            4'd2:                   len = leap ? 5'd29 : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
            [4'd1:4'd12]:           len = 5'd31;
            default:                len = 5'd0;
        endcase
        return len;
    endfunction

endpackage

/* hw/rtl/dcdn_stream_if.sv */
// valid/ready stream channel carrying one word of type T
// no dependencies
interface dcdn_stream_if #(
    parameter type T = logic
) ();
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* hw/rtl/dcdn_calc.sv */
// date check, day numbering and ordering check for one record
// depends on dcdn_pkg
module dcdn_calc
    import dcdn_pkg::*;
(
    input  rec_word_t   rec,
    input  logic        have_prev,
    input  logic [19:0] prev_day,
    output res_word_t   res
);

    logic [11:0] year_m1;
    logic [24:0] prod_y;
    logic [24:0] prod_n;
    logic [5:0]  cent_y;
    logic [5:0]  cent_n;
    logic [11:0] cent_y_x100;
    logic        div100;
    logic        leap;
    logic [10:0] leaps_n;
    logic [10:0] leap_diff;
    logic [11:0] year_off;
    logic [4:0]  len;
    logic [8:0]  days_prior;
    logic [19:0] dn;
    logic        date_ok;
    logic        pos;

    always_comb
    begin
        year_m1     = rec.year - 12'd1;
        prod_y      = 25'(rec.year) * 25'(RECIP_100);
        prod_n      = 25'(year_m1) * 25'(RECIP_100);
        cent_y      = prod_y[24:RECIP_SHIFT];
        cent_n      = prod_n[24:RECIP_SHIFT];
        cent_y_x100 = 12'(cent_y) * 12'd100;
        div100      = (cent_y_x100 == rec.year);
        // a century year is leap only when its century count is a multiple of four
        leap        = div100 ? (cent_y[1:0] == 2'd0) : (rec.year[1:0] == 2'd0);

        // leap years in 1..year-1 in closed form
        leaps_n     = 11'(year_m1[11:2]) - 11'(cent_n) + 11'(cent_n[5:2]);
        leap_diff   = leaps_n - BASE_LEAPS;
        year_off    = rec.year - BASE_YEAR;

        len         = month_days(rec.month, leap);
        days_prior  = CUM_DAYS[rec.month] + ((leap && rec.month > 4'd2) ? 9'd1 : 9'd0);
        date_ok     = (rec.year >= BASE_YEAR) && (rec.day != 5'd0) && (rec.day <= len);

        dn          = 20'(year_off) * DAYS_PER_YEAR + 20'(leap_diff)
                    + 20'(days_prior) + 20'(rec.day);
        pos         = !rec.points[15] && (rec.points != 16'sd0);

        if (!date_ok)
        begin
            res.status     = ST_BAD_DATE;
            res.day_number = '0;
        end
        else
        begin
            res.day_number = dn;
            if (have_prev && dn < prev_day)
                res.status = ST_EARLY;
            else if (!pos)
                res.status = ST_NOT_POS;
            else
                res.status = ST_OK;
        end
    end

endmodule

/* hw/rtl/date_check_and_day_number.sv */
// Dated-record checker. Each word on rec (year, month, day, points) yields exactly one
// word on res with a status and the day number counted from 1 January 1800 (day 1).
// Checks run in order: valid Gregorian date from 1800 on (status 1, day number 0),
// not earlier than the last accepted record (status 2), points at least 1 (status 3);
// status 0 accepts the record and makes its day number the new lower bound. A record word
// taken from rec is held in the input register and moves into the result register once that
// is free, and one word is taken every cycle while res takes each result: the whole check is
// one pass of logic between the input register and the result register, and the stored
// previous day number is updated on the same edge as the result register.
`include "date_check_and_day_number_assert.svh"
module date_check_and_day_number
    import dcdn_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    dcdn_stream_if.sink   rec,
    dcdn_stream_if.source res
);

    logic        s1_valid_reg;
    logic        s1_valid_next;
    rec_word_t   s1_word_reg;
    logic        s2_valid_reg;
    logic        s2_valid_next;
    res_word_t   s2_word_reg;
    logic        have_prev_reg;
    logic        have_prev_next;
    logic [19:0] prev_day_reg;
    logic [19:0] prev_day_next;

    logic        rec_fire;
    logic        s2_free;
    logic        s2_load;
    res_word_t   calc_res;

    dcdn_calc u_calc (
        .rec       (s1_word_reg),
        .have_prev (have_prev_reg),
        .prev_day  (prev_day_reg),
        .res       (calc_res)
    );

    always_comb
    begin
        s2_free   = !s2_valid_reg || res.ready;
        s2_load   = s1_valid_reg && s2_free;
        rec.ready = !s1_valid_reg || s2_free;
        rec_fire  = rec.valid && rec.ready;

        s1_valid_next = rec_fire || (s1_valid_reg && !s2_load);
        s2_valid_next = s2_load || (s2_valid_reg && !res.ready);

        have_prev_next = have_prev_reg;
        prev_day_next  = prev_day_reg;
        if (s2_load && calc_res.status == ST_OK)
        begin
            have_prev_next = 1'b1;
            prev_day_next  = calc_res.day_number;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            have_prev_reg <= 1'b0;
            prev_day_reg  <= '0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            s2_valid_reg  <= s2_valid_next;
            have_prev_reg <= have_prev_next;
            prev_day_reg  <= prev_day_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (rec_fire)
            s1_word_reg <= rec.data;
        if (s2_load)
            s2_word_reg <= calc_res;
    end

    assign res.valid = s2_valid_reg;
    assign res.data  = s2_word_reg;

    `DCDN_ASSERT_NOW(a_bad_date_zero, s2_valid_reg && s2_word_reg.status == ST_BAD_DATE,
        s2_word_reg.day_number == 20'd0, "invalid date with nonzero day number")
    `DCDN_ASSERT_NEXT(a_prev_follows_ok, s2_load && calc_res.status == ST_OK,
        have_prev_reg && prev_day_reg == s2_word_reg.day_number,
        "accepted record did not update previous day number")
    `DCDN_ASSERT_NEXT(a_prev_monotonic, have_prev_reg,
        have_prev_reg && prev_day_reg >= $past(prev_day_reg),
        "previous day number went backwards")
    `DCDN_ASSERT_NOW(a_full_stall, s1_valid_reg && s2_valid_reg && !res.ready,
        !rec.ready, "word taken while both stages are held")

endmodule
